// ----- design/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants, types and field layout for the definite-time protection
// bank.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int NUM_ELEMENTS = 32;
    localparam int MIN_DELAY    = 3;

    localparam int ELEM_IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    // field widths
    localparam int MODE_W   = 2;
    localparam int ELEM_W   = 6;
    localparam int VALUE_W  = 16;
    localparam int TIMER_W  = 16;
    localparam int MASK_W   = 32;

    // input tdata layout
    localparam int IN_ELEM_LSB   = 0;
    localparam int IN_SAMPLE_LSB = IN_ELEM_LSB + ELEM_W;
    localparam int IN_THR_LSB    = IN_SAMPLE_LSB + VALUE_W;
    localparam int IN_DELAY_LSB  = IN_THR_LSB + VALUE_W;
    localparam int IN_LOCK_LSB   = IN_DELAY_LSB + VALUE_W;
    localparam int IN_DATA_W     = 56;

    // output tdata layout
    localparam int OUT_TIMER_LSB  = 0;
    localparam int OUT_TRIP_LSB   = OUT_TIMER_LSB + TIMER_W;
    localparam int OUT_ALARM_LSB  = OUT_TRIP_LSB + 1;
    localparam int OUT_NEWEV_LSB  = OUT_ALARM_LSB + 1;
    localparam int OUT_FREEZE_LSB = OUT_NEWEV_LSB + 1;
    localparam int OUT_ACTIVE_LSB = OUT_FREEZE_LSB + 1;
    localparam int OUT_LATCH_LSB  = OUT_ACTIVE_LSB + 1;
    localparam int OUT_OPEN_LSB   = OUT_LATCH_LSB + MASK_W;
    localparam int OUT_DATA_W     = 56;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_OVER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNDER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    typedef logic [NUM_ELEMENTS-1:0] t_elem_mask;
    typedef logic [TIMER_W-1:0]      t_timer;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture input transaction, start timer read
        logic exec;   // update state and load the result register
    } t_dtp_cmd;

endpackage

// ----- design/definite_time_protection_bank_unit.sv -----
// ----------------------------------------------------------------------------
// definite_time_protection_bank_unit
// Bank of definite-time over/under protection elements with trip/alarm
// selection, event flags and breaker open request.
// ----------------------------------------------------------------------------
// For each input transaction the element's pickup timer is read from the timer
// memory in the accept cycle and updated, together with the flags, in the
// update step, which also loads the result register. A new transaction is
// accepted while a result waits; the update step waits only while the result
// register is still full and not being read, and no new transaction is
// accepted until the update step of the last one has been done.
// Elements are selected by index, one sample at a time, and tick transactions
// age the pending and active flags.
module definite_time_protection_bank_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: trip enable mask
    input  logic                           i_cfg_wr_en,
    input  logic [dtp_pkg::MASK_W-1:0]     i_cfg_wr_data,
    // sample stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // element[5:0], sample[21:6], threshold[37:22], delay_ticks[53:38],
    // lock[54], zero[55]
    input  logic [dtp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode[1:0]
    input  logic [dtp_pkg::MODE_W-1:0]     i_s_tuser,
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // timer_value[15:0], tripped[16], alarmed[17], new_event[18],
    // freeze_record[19], any_active[20], latched_mask[52:21],
    // open_request[53], zero[55:54]
    output logic [dtp_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import dtp_pkg::*;

    t_dtp_cmd w_cmd;

    dtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    dtp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

// ----- design/dtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtp_ctrl
// Controller for the protection bank: input/output handshakes and sequencing
// of the read and update steps.
// ----------------------------------------------------------------------------
module dtp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output dtp_pkg::t_dtp_cmd o_cmd
);
    import dtp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept, w_fire;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // update only once the result register is free or being emptied
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd.load = w_accept;
    assign o_cmd.exec = w_fire;

`ifndef SYNTHESIS
    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter update step");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("update step did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !i_m_tready) |=> (r_state == S_EXEC))
        else $error("pending result would be overwritten");
`endif

endmodule

// ----- design/dtp_dpath.sv -----
// ----------------------------------------------------------------------------
// dtp_dpath
// Datapath for the protection bank: timer memory, element flags, trip mask
// and the result register.
// ----------------------------------------------------------------------------
module dtp_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtp_pkg::t_dtp_cmd                i_cmd,
    input  logic [dtp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic [dtp_pkg::MODE_W-1:0]       i_s_tuser,
    input  logic                             i_cfg_wr_en,
    input  logic [dtp_pkg::MASK_W-1:0]       i_cfg_wr_data,
    output logic [dtp_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import dtp_pkg::*;

    // timer memory with per-entry valid bits standing in for the zero reset
    t_timer                r_mem [NUM_ELEMENTS];
    t_elem_mask            r_vld;
    t_timer                r_rd_data;
    logic                  r_rd_vld;

    // captured transaction
    logic [MODE_W-1:0]     r_mode;
    logic [ELEM_W-1:0]     r_elem;
    logic [VALUE_W-1:0]    r_sample;
    logic [VALUE_W-1:0]    r_thr;
    logic [VALUE_W-1:0]    r_delay;
    logic                  r_lock;

    logic [MASK_W-1:0]     r_trip_mask;
    t_elem_mask            r_pend, n_pend;
    t_elem_mask            r_act, n_act;
    t_elem_mask            r_latched, n_latched;
    logic                  r_overall, n_overall;
    logic                  r_open, n_open;
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] w_result;

    logic [ELEM_W-1:0]     w_in_elem;
    logic [ELEM_IDX_W-1:0] w_in_idx;
    logic [ELEM_IDX_W-1:0] w_idx;
    t_elem_mask            w_bit;
    logic                  w_is_tick;
    logic                  w_in_range;
    t_timer                w_timer_old;
    t_timer                n_timer;
    t_timer                w_delay_eff;
    logic [TIMER_W:0]      w_inc;
    logic                  w_pickup;
    logic                  w_rst_band;
    logic                  w_operate;
    logic                  w_trip;
    logic                  w_alarm;
    logic                  w_newev;
    logic                  w_freeze;

    assign w_in_elem = i_s_tdata[IN_ELEM_LSB +: ELEM_W];
    assign w_in_idx  = w_in_elem[ELEM_IDX_W-1:0];
    assign w_idx     = r_elem[ELEM_IDX_W-1:0];
    assign w_bit     = t_elem_mask'(1) << w_idx;

    assign w_is_tick   = (r_mode == MODE_TICK);
    assign w_in_range  = ((r_mode == MODE_OVER) || (r_mode == MODE_UNDER))
                         && (r_elem < ELEM_W'(NUM_ELEMENTS));
    assign w_timer_old = r_rd_vld ? r_rd_data : '0;
    assign w_delay_eff = (r_delay < TIMER_W'(MIN_DELAY)) ? TIMER_W'(MIN_DELAY) : r_delay;
    assign w_inc       = {1'b0, w_timer_old} + (TIMER_W+1)'(1);

    always_comb begin
        if (r_mode == MODE_OVER) begin
            w_pickup   = r_sample > r_thr;
            w_rst_band = r_sample < (r_thr >> 1);
        end else begin
            w_pickup   = r_sample < r_thr;
            // doubled threshold kept at full width
            w_rst_band = {1'b0, r_sample} > {r_thr, 1'b0};
        end
    end

    always_comb begin
        n_timer   = w_timer_old;
        w_operate = 1'b0;
        if (r_lock) begin
            if (w_timer_old != '0) begin
                n_timer = w_timer_old - TIMER_W'(1);
            end
        end else if (w_pickup) begin
            if (w_inc >= {1'b0, w_delay_eff}) begin
                n_timer   = w_delay_eff;
                w_operate = 1'b1;
            end else begin
                n_timer = w_inc[TIMER_W-1:0];
            end
        end else if (w_rst_band) begin
            n_timer = '0;
        end else if (w_timer_old != '0) begin
            n_timer = w_timer_old - TIMER_W'(1);
        end
    end

    always_comb begin
        n_pend    = r_pend;
        n_act     = r_act;
        n_latched = r_latched;
        n_overall = r_overall;
        n_open    = r_open;
        w_trip    = 1'b0;
        w_alarm   = 1'b0;
        w_newev   = 1'b0;
        w_freeze  = 1'b0;
        if (w_is_tick) begin
            n_act     = r_pend;
            n_pend    = '0;
            n_overall = |r_pend;
            n_open    = 1'b0;
        end else if (w_in_range && w_operate) begin
            w_newev   = ((r_pend | r_act) & w_bit) == '0;
            w_trip    = r_trip_mask[w_idx];
            w_alarm   = !r_trip_mask[w_idx];
            n_open    = r_open | r_trip_mask[w_idx];
            n_pend    = r_pend | w_bit;
            n_act     = r_act & ~w_bit;
            n_latched = r_latched | w_bit;
            // pending was just set, so activity is now present
            w_freeze  = !r_overall;
            n_overall = 1'b1;
        end
    end

    always_comb begin
        w_result = '0;
        w_result[OUT_TIMER_LSB +: TIMER_W] = w_in_range ? n_timer : '0;
        w_result[OUT_TRIP_LSB]             = w_in_range && w_trip;
        w_result[OUT_ALARM_LSB]            = w_in_range && w_alarm;
        w_result[OUT_NEWEV_LSB]            = w_in_range && w_newev;
        w_result[OUT_FREEZE_LSB]           = w_in_range && w_freeze;
        w_result[OUT_ACTIVE_LSB]           = n_overall;
        w_result[OUT_LATCH_LSB +: MASK_W]  = MASK_W'(n_latched);
        w_result[OUT_OPEN_LSB]             = n_open;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= r_mem[w_in_idx];
            r_mode    <= i_s_tuser;
            r_elem    <= w_in_elem;
            r_sample  <= i_s_tdata[IN_SAMPLE_LSB +: VALUE_W];
            r_thr     <= i_s_tdata[IN_THR_LSB +: VALUE_W];
            r_delay   <= i_s_tdata[IN_DELAY_LSB +: VALUE_W];
            r_lock    <= i_s_tdata[IN_LOCK_LSB];
        end
        if (i_cmd.exec && w_in_range) begin
            r_mem[w_idx] <= n_timer;
        end
        if (i_cmd.exec) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_trip_mask <= '0;
            r_pend      <= '0;
            r_act       <= '0;
            r_latched   <= '0;
            r_overall   <= 1'b0;
            r_open      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_trip_mask <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_rd_vld <= r_vld[w_in_idx];
            end
            if (i_cmd.exec) begin
                if (w_in_range) begin
                    r_vld <= r_vld | w_bit;
                end
                r_pend    <= n_pend;
                r_act     <= n_act;
                r_latched <= n_latched;
                r_overall <= n_overall;
                r_open    <= n_open;
            end
        end
    end

    assign o_m_tdata = r_out;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & r_act) == '0)
        else $error("element both pending and active");

    a_overall_tracks_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overall == |(r_pend | r_act))
        else $error("overall activity out of step with element flags");

    a_latched_covers_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_latched) == '0)
        else $error("pending element missing from latched mask");
`endif

endmodule
